// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge while reset is released.
`define LPD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define LPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/lpd_pkg.sv -----
`timescale 1ns / 1ps

package lpd_pkg;

    localparam int MAX_ARGS_DEFAULT = 1024;

    localparam int LEN_W  = 24;   // message length register and byte counters
    localparam int ARGC_W = 11;   // argument count
    localparam int IDX_W  = 10;   // argument index on the output

    // Result kinds
    localparam logic [1:0] KIND_HDR  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_TOO_LONG = 3'd1;
    localparam logic [2:0] ERR_TOO_MANY = 3'd2;
    localparam logic [2:0] ERR_TOO_SHORT = 3'd3;
    localparam logic [2:0] ERR_OVERRUN  = 3'd4;
    localparam logic [2:0] ERR_TRAILING = 3'd5;

    // Configuration register indexes
    localparam logic CFG_MAX_LEN  = 1'b0;
    localparam logic CFG_MAX_ARGC = 1'b1;

    localparam logic [LEN_W-1:0]  MAX_LEN_RESET  = 24'd4096;
    localparam logic [ARGC_W-1:0] MAX_ARGC_RESET = 11'd1024;

    typedef struct packed {
        logic [LEN_W-1:0]  max_len;
        logic [ARGC_W-1:0] max_argc;
    } t_cfg;

    // One result item; the fields other than kind and request_done keep their order in output tdata.
    typedef struct packed {
        logic [1:0]        kind;
        logic [2:0]        error_code;
        logic [ARGC_W-1:0] arg_count;
        logic              request_done;
        logic              arg_done;
        logic [IDX_W-1:0]  arg_index;
        logic [7:0]        data_out;
    } t_result;

    typedef struct packed {
        logic              in_err;
        logic [2:0]        sticky_error;
    } t_status;

endpackage

// ----- hdl/lpd_slice.sv -----
`timescale 1ns / 1ps

// Two-entry register slice: registered data and registered ready.
module lpd_slice #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic             r_valid;
    logic             r_skid_valid;
    logic [WIDTH-1:0] r_data;
    logic [WIDTH-1:0] r_skid_data;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_ready || !r_valid) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_valid <= i_valid;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ready || !r_valid) begin
            r_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (i_valid && !r_skid_valid) begin
            r_skid_data <= i_data;
        end
    end

endmodule

// ----- hdl/lpd_core.sv -----
`timescale 1ns / 1ps

// Per-byte framing state and result formation, one byte per enabled cycle.
module lpd_core #(
    parameter int MAX_ARGS = lpd_pkg::MAX_ARGS_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    input  lpd_pkg::t_cfg    i_cfg,
    output lpd_pkg::t_result o_result,
    output lpd_pkg::t_status o_status
);

    localparam int LW = lpd_pkg::LEN_W;
    localparam int AW = lpd_pkg::ARGC_W;
    localparam int ARGS_CAP_I = (MAX_ARGS > (2 ** AW) - 1) ? (2 ** AW) - 1 : MAX_ARGS;
    localparam logic [AW-1:0] ARGS_CAP = AW'(ARGS_CAP_I);

    localparam logic [2:0] PH_LEN    = 3'd0;
    localparam logic [2:0] PH_ARGC   = 3'd1;
    localparam logic [2:0] PH_ARGLEN = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_ERR    = 3'd4;

    logic [2:0]    r_phase, n_phase;
    logic [1:0]    r_fbc, n_fbc;
    logic [23:0]   r_acc, n_acc;
    logic [LW-1:0] r_mbl, n_mbl;
    logic [AW-1:0] r_al, n_al;
    logic [AW-1:0] r_cur, n_cur;
    logic [LW-1:0] r_abl, n_abl;
    logic [AW-1:0] r_total, n_total;
    logic [2:0]    r_err, n_err;

    logic [31:0]   fld;
    logic          complete;
    logic [LW-1:0] mbl_c;
    logic [LW-1:0] abl_c;
    logic [AW-1:0] al_dec;
    logic [AW-1:0] limit;
    logic          do_after;
    logic [AW-1:0] after_al;
    logic [1:0]    kind;
    logic [lpd_pkg::IDX_W-1:0] idx;
    logic          a_done;
    logic          q_done;

    assign fld      = {i_byte, r_acc};
    assign complete = (r_fbc == 2'd3);
    assign mbl_c    = (r_mbl != '0) ? r_mbl - LW'(1) : r_mbl;
    assign abl_c    = (r_abl != '0) ? r_abl - LW'(1) : r_abl;
    assign al_dec   = (r_al != '0) ? r_al - AW'(1) : r_al;
    assign limit    = (i_cfg.max_argc < ARGS_CAP) ? i_cfg.max_argc : ARGS_CAP;

    always_comb begin
        n_phase  = r_phase;
        n_fbc    = r_fbc;
        n_acc    = r_acc;
        n_mbl    = r_mbl;
        n_al     = r_al;
        n_cur    = r_cur;
        n_abl    = r_abl;
        n_total  = r_total;
        n_err    = r_err;
        kind     = lpd_pkg::KIND_HDR;
        idx      = '0;
        a_done   = 1'b0;
        q_done   = 1'b0;
        do_after = 1'b0;
        after_al = '0;

        // shift the byte into the little-endian field in the field phases
        if (r_phase == PH_LEN || r_phase == PH_ARGC || r_phase == PH_ARGLEN) begin
            if (complete) begin
                n_fbc = 2'd0;
                n_acc = '0;
            end else begin
                n_fbc = r_fbc + 2'd1;
                unique case (r_fbc)
                    2'd0:    n_acc[7:0]   = i_byte;
                    2'd1:    n_acc[15:8]  = i_byte;
                    default: n_acc[23:16] = i_byte;
                endcase
            end
        end

        unique case (r_phase)
            PH_LEN: begin
                if (complete) begin
                    if (fld > {8'd0, i_cfg.max_len}) begin
                        n_err   = lpd_pkg::ERR_TOO_LONG;
                        n_phase = PH_ERR;
                    end else if (fld < 32'd4) begin
                        n_err   = lpd_pkg::ERR_TOO_SHORT;
                        n_phase = PH_ERR;
                    end else begin
                        n_mbl   = fld[LW-1:0];
                        n_phase = PH_ARGC;
                    end
                end
            end
            PH_ARGC: begin
                n_mbl = mbl_c;
                if (complete) begin
                    if (fld > {21'd0, limit}) begin
                        n_err   = lpd_pkg::ERR_TOO_MANY;
                        n_phase = PH_ERR;
                    end else begin
                        n_total  = fld[AW-1:0];
                        n_al     = fld[AW-1:0];
                        n_cur    = '0;
                        do_after = 1'b1;
                        after_al = fld[AW-1:0];
                    end
                end
            end
            PH_ARGLEN: begin
                idx   = r_cur[lpd_pkg::IDX_W-1:0];
                n_mbl = mbl_c;
                if (complete) begin
                    if (fld > {8'd0, mbl_c}) begin
                        n_err   = lpd_pkg::ERR_OVERRUN;
                        n_phase = PH_ERR;
                    end else if (fld == 32'd0) begin
                        a_done   = 1'b1;
                        n_al     = al_dec;
                        n_cur    = r_cur + AW'(1);
                        do_after = 1'b1;
                        after_al = al_dec;
                    end else begin
                        n_abl   = fld[LW-1:0];
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                kind  = lpd_pkg::KIND_DATA;
                idx   = r_cur[lpd_pkg::IDX_W-1:0];
                n_mbl = mbl_c;
                n_abl = abl_c;
                if (abl_c == '0) begin
                    a_done   = 1'b1;
                    n_al     = al_dec;
                    n_cur    = r_cur + AW'(1);
                    do_after = 1'b1;
                    after_al = al_dec;
                end
            end
            default: begin
                n_phase = PH_ERR;
            end
        endcase

        // end of a count field or an argument: next argument, end, or error
        if (do_after) begin
            if (after_al == '0) begin
                if (mbl_c == '0) begin
                    q_done  = 1'b1;
                    n_phase = PH_LEN;
                end else begin
                    n_err   = lpd_pkg::ERR_TRAILING;
                    n_phase = PH_ERR;
                end
            end else if (mbl_c < LW'(4)) begin
                n_err   = lpd_pkg::ERR_OVERRUN;
                n_phase = PH_ERR;
            end else begin
                n_phase = PH_ARGLEN;
            end
        end

        if (n_phase == PH_ERR && n_err == lpd_pkg::ERR_NONE) begin
            n_err = lpd_pkg::ERR_OVERRUN;
        end
    end

    always_comb begin
        o_result.data_out = i_byte;
        if (n_phase == PH_ERR) begin
            o_result.kind         = lpd_pkg::KIND_ERR;
            o_result.error_code   = n_err;
            o_result.arg_count    = '0;
            o_result.request_done = 1'b0;
            o_result.arg_done     = 1'b0;
            o_result.arg_index    = '0;
        end else begin
            o_result.kind         = kind;
            o_result.error_code   = lpd_pkg::ERR_NONE;
            o_result.arg_count    = q_done ? n_total : '0;
            o_result.request_done = q_done;
            o_result.arg_done     = a_done;
            o_result.arg_index    = idx;
        end
    end

    assign o_status.in_err       = (r_phase == PH_ERR);
    assign o_status.sticky_error = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN;
            r_fbc   <= '0;
            r_acc   <= '0;
            r_mbl   <= '0;
            r_al    <= '0;
            r_cur   <= '0;
            r_abl   <= '0;
            r_total <= '0;
            r_err   <= lpd_pkg::ERR_NONE;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_fbc   <= n_fbc;
            r_acc   <= n_acc;
            r_mbl   <= n_mbl;
            r_al    <= n_al;
            r_cur   <= n_cur;
            r_abl   <= n_abl;
            r_total <= n_total;
            r_err   <= n_err;
        end
    end

endmodule

// ----- hdl/length_prefixed_request_deframer.sv -----
`timescale 1ns / 1ps
// A byte passes through the input slice register and then the result slice register on its way to the master side.
// Throughput: one byte per cycle while the result stream accepts, set by the single-pass framing update in lpd_core.
// Both stream sides are register slices, so a stalled output does not stop input at once.
// Reset (synchronous, active low): framing restarts at the message length field,
// the sticky error clears, the limits return to 4096 bytes and 1024 arguments.

`include "assert_macros.svh"

module length_prefixed_request_deframer #(
    parameter int MAX_ARGS = lpd_pkg::MAX_ARGS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [23:0] i_cfg_data,
    // input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] data_out, [17:8] arg_index, [18] arg_done,
                                        // [29:19] arg_count, [32:30] error_code, rest zero
    output logic        m_axis_tlast,   // request_done
    output logic [1:0]  m_axis_tuser    // kind
);

    localparam int RES_W = $bits(lpd_pkg::t_result);

    lpd_pkg::t_cfg    r_cfg;
    lpd_pkg::t_result core_res;
    lpd_pkg::t_result out_res;
    lpd_pkg::t_status core_st;

    logic             in_valid;
    logic [7:0]       in_byte;
    logic             res_ready;
    logic             fire;
    logic [RES_W-1:0] out_bits;

    // Configuration: always ready, write the addressed limit.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_len  <= lpd_pkg::MAX_LEN_RESET;
            r_cfg.max_argc <= lpd_pkg::MAX_ARGC_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lpd_pkg::CFG_MAX_LEN:  r_cfg.max_len  <= i_cfg_data;
                lpd_pkg::CFG_MAX_ARGC: r_cfg.max_argc <= i_cfg_data[lpd_pkg::ARGC_W-1:0];
            endcase
        end
    end

    // Input slice: hold incoming bytes so tready is a register.
    lpd_slice #(
        .WIDTH(8)
    ) u_in_slice (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (in_valid),
        .i_ready (res_ready),
        .o_data  (in_byte)
    );

    // Advance the framing state whenever a byte moves into the result slice.
    assign fire = in_valid && res_ready;

    lpd_core #(
        .MAX_ARGS(MAX_ARGS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (in_byte),
        .i_cfg    (r_cfg),
        .o_result (core_res),
        .o_status (core_st)
    );

    // Result slice: the result register in front of the master side.
    lpd_slice #(
        .WIDTH(RES_W)
    ) u_out_slice (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_ready (res_ready),
        .i_data  (core_res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_bits)
    );

    assign out_res = lpd_pkg::t_result'(out_bits);

    // Pack the result fields, data_out in the lowest bits.
    assign m_axis_tdata = {7'd0, out_res.error_code, out_res.arg_count, out_res.arg_done,
                           out_res.arg_index, out_res.data_out};
    assign m_axis_tlast = out_res.request_done;
    assign m_axis_tuser = out_res.kind;

    // An error result carries a code, and only an error result does.
    `LPD_ASSERT(a_err_code_kind, i_clk, i_rst_n, !m_axis_tvalid || ((m_axis_tuser == lpd_pkg::KIND_ERR) == (m_axis_tdata[32:30] != lpd_pkg::ERR_NONE)), "error code and kind disagree")
    // A completed request is never reported on an error result.
    `LPD_ASSERT(a_done_kind, i_clk, i_rst_n, !(m_axis_tvalid && m_axis_tlast) || (m_axis_tuser != lpd_pkg::KIND_ERR), "request_done on an error result")
    // Once in error, stay in error until reset.
    `LPD_ASSERT(a_err_sticky, i_clk, i_rst_n, core_st.in_err |=> core_st.in_err, "error state left without reset")
    // The error state always holds a nonzero code.
    `LPD_ASSERT(a_err_has_code, i_clk, i_rst_n, !core_st.in_err || (core_st.sticky_error != lpd_pkg::ERR_NONE), "error state without code")

endmodule
